// ===== rtl/ptb_pkg.sv =====
// Package: shared constants, codes and types of the per-client token bucket table.
package ptb_pkg;

    localparam int TABLE_ENTRIES       = 64;
    localparam int IDX_W               = $clog2(TABLE_ENTRIES);
    localparam int TOKEN_FRACTION_BITS = 8;
    localparam int RATE_FRACTION_BITS  = 8;

    localparam int REQ_TYPE_W = 2;
    localparam int ADDR_W     = 32;
    localparam int TIME_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;

    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_CAP_W      = 16;
    localparam int CFG_RATE_W     = 16;
    localparam int CFG_TIMEOUT_W  = 32;

    localparam int TOKEN_W    = CFG_CAP_W + TOKEN_FRACTION_BITS;
    localparam int SHIFT_UP   = (TOKEN_FRACTION_BITS >= RATE_FRACTION_BITS) ?
                                (TOKEN_FRACTION_BITS - RATE_FRACTION_BITS) : 0;
    localparam int SHIFT_DN   = (TOKEN_FRACTION_BITS < RATE_FRACTION_BITS) ?
                                (RATE_FRACTION_BITS - TOKEN_FRACTION_BITS) : 0;
    localparam int SRATE_W    = CFG_RATE_W + SHIFT_UP;
    localparam int PROD_W     = TIME_W + SRATE_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TOKEN_W-1:0] ONE_TOKEN = TOKEN_W'(1) << TOKEN_FRACTION_BITS;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_TOUCH = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_CHECK = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_SWEEP = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT    = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]  key;
        logic [TOKEN_W-1:0] tokens;
        logic [TIME_W-1:0]  last_seen;
    } slot_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_MUL,
        ST_FILL,
        ST_TAKE,
        ST_DONE
    } ptb_state_t;

    // refill rate rescaled to the token fraction format
    function automatic logic [SRATE_W-1:0] scale_rate(input logic [CFG_RATE_W-1:0] rate);
        logic [SRATE_W-1:0] wide;
        wide = SRATE_W'(rate);
        return (wide << SHIFT_UP) >> SHIFT_DN;
    endfunction

endpackage

// ===== rtl/ptb_ifs.sv =====
// Interfaces: request, response and configuration channels.
interface ptb_req_if import ptb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [ADDR_W-1:0]     client_addr;
    logic [TIME_W-1:0]     now_seconds;

    modport source (output valid, req_type, client_addr, now_seconds, input ready);
    modport sink   (input valid, req_type, client_addr, now_seconds, output ready);
endinterface

interface ptb_rsp_if import ptb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                limited;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  evicted_count;

    modport source (output valid, limited, status, evicted_count, input ready);
    modport sink   (input valid, limited, status, evicted_count, output ready);
endinterface

interface ptb_cfg_if import ptb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/per_client_token_bucket_table.sv =====
// Top level: per-client token bucket table with a scanned slot memory.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  cfg     | in  | valid / ready | index, data (capacity, rate, timeout)
//  req     | in  | valid / ready | req_type, client_addr, now_seconds
//  rsp     | out | valid / ready | limited, status, evicted_count
//
// Touch, check and sweep requests scan all TABLE_ENTRIES slots through the
// one-read-port slot memory, one slot a cycle, then drain and decide; a check
// that hits then goes through the multiply, refill and take steps.
// Reset clears the slot valid flops at once; config takes the reset values.
// A new request is taken while the previous response still waits; the block
// holds in its last step until the response register is free.
module per_client_token_bucket_table
    import ptb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ptb_cfg_if.sink     cfg,
    ptb_req_if.sink     req,
    ptb_rsp_if.source   rsp
);

    slot_entry_t slot_mem [TABLE_ENTRIES];
    slot_entry_t rd_data_reg;
    logic        rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_entry_t wr_data;

    ptb_state_t state_reg, state_next;

    logic [CFG_CAP_W-1:0]     cap_reg, cap_next;
    logic [CFG_RATE_W-1:0]    rate_reg, rate_next;
    logic [CFG_TIMEOUT_W-1:0] timeout_reg, timeout_next;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic [REQ_TYPE_W-1:0] req_type_reg, req_type_next;
    logic [ADDR_W-1:0]     key_reg, key_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_reg, free_next;
    logic [TOKEN_W-1:0]    tok_reg, tok_next;
    logic [TIME_W-1:0]     elapsed_reg, elapsed_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [TOKEN_W-1:0]    fill_reg, fill_next;
    logic                  limited_reg, limited_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [COUNT_W-1:0]    evict_reg, evict_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_limited_reg, out_limited_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    // slot memory, one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign cfg.ready         = 1'b1;
    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.limited       = out_limited_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.evicted_count = out_count_reg;

    always_comb
    begin
        logic               entry_valid;
        logic [TIME_W-1:0]  idle;
        logic [TOKEN_W-1:0] full;
        logic [TOKEN_W-1:0] tok_clamped;
        logic [PROD_W-1:0]  room;

        state_next       = state_reg;
        cap_next         = cap_reg;
        rate_next        = rate_reg;
        timeout_next     = timeout_reg;
        valid_next       = valid_reg;
        scan_idx_next    = scan_idx_reg;
        chk_vld_next     = chk_vld_reg;
        chk_idx_next     = chk_idx_reg;
        req_type_next    = req_type_reg;
        key_next         = key_reg;
        now_next         = now_reg;
        found_next       = found_reg;
        slot_next        = slot_reg;
        free_found_next  = free_found_reg;
        free_next        = free_reg;
        tok_next         = tok_reg;
        elapsed_next     = elapsed_reg;
        prod_next        = prod_reg;
        fill_next        = fill_reg;
        limited_next     = limited_reg;
        status_next      = status_reg;
        evict_next       = evict_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_limited_next = out_limited_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;

        rd_en   = 1'b0;
        rd_addr = scan_idx_reg;
        wr_en   = 1'b0;
        wr_addr = slot_reg;
        wr_data = '{key: key_reg, tokens: tok_reg, last_seen: now_reg};

        entry_valid = valid_reg[chk_idx_reg];
        idle        = (now_reg >= rd_data_reg.last_seen) ?
                      (now_reg - rd_data_reg.last_seen) : '0;
        full        = TOKEN_W'(cap_reg) << TOKEN_FRACTION_BITS;
        tok_clamped = (tok_reg > full) ? full : tok_reg;
        room        = PROD_W'(full - tok_clamped);

        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BUCKET_CAPACITY: cap_next     = cfg.data[CFG_CAP_W-1:0];
                CFG_REFILL_RATE:     rate_next    = cfg.data[CFG_RATE_W-1:0];
                CFG_IDLE_TIMEOUT:    timeout_next = cfg.data[CFG_TIMEOUT_W-1:0];
                default: ;
            endcase
        end

        // compare stage of the scan: data of slot chk_idx_reg is in rd_data_reg
        if ((state_reg == ST_SCAN || state_reg == ST_DRAIN) && chk_vld_reg)
        begin
            if (req_type_reg == REQ_SWEEP)
            begin
                if (entry_valid && (idle > timeout_reg))
                begin
                    valid_next[chk_idx_reg] = 1'b0;
                    if (evict_reg != COUNT_MAX)
                    begin
                        evict_next = evict_reg + 1'b1;
                    end
                end
            end
            else
            begin
                if (entry_valid && (rd_data_reg.key == key_reg) && !found_reg)
                begin
                    found_next   = 1'b1;
                    slot_next    = chk_idx_reg;
                    tok_next     = rd_data_reg.tokens;
                    elapsed_next = idle;
                end
                if (!entry_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_next       = chk_idx_reg;
                end
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    req_type_next   = req.req_type;
                    key_next        = req.client_addr;
                    now_next        = req.now_seconds;
                    scan_idx_next   = '0;
                    chk_vld_next    = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    limited_next    = 1'b0;
                    status_next     = STATUS_DONE;
                    evict_next      = '0;
                    if (req.req_type == REQ_TOUCH || req.req_type == REQ_CHECK ||
                        req.req_type == REQ_SWEEP)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en        = 1'b1;
                chk_vld_next = 1'b1;
                chk_idx_next = scan_idx_reg;
                if (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                chk_vld_next = 1'b0;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_DONE;
                case (req_type_reg)
                    REQ_TOUCH:
                    begin
                        if (found_reg)
                        begin
                            wr_en = 1'b1;
                        end
                        else if (free_found_reg)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = free_reg;
                            wr_data    = '{key: key_reg, tokens: full, last_seen: now_reg};
                            valid_next[free_reg] = 1'b1;
                        end
                        else
                        begin
                            status_next = STATUS_FULL;
                        end
                    end
                    REQ_CHECK:
                    begin
                        if (found_reg)
                        begin
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            status_next = STATUS_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(elapsed_reg) * PROD_W'(scale_rate(rate_reg));
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (prod_reg > room)
                begin
                    fill_next = full;
                end
                else
                begin
                    fill_next = tok_clamped + prod_reg[TOKEN_W-1:0];
                end
                state_next = ST_TAKE;
            end
            ST_TAKE:
            begin
                wr_en = 1'b1;
                if (fill_reg < ONE_TOKEN)
                begin
                    limited_next = 1'b1;
                    wr_data      = '{key: key_reg, tokens: fill_reg, last_seen: now_reg};
                end
                else
                begin
                    wr_data = '{key: key_reg, tokens: fill_reg - ONE_TOKEN,
                                last_seen: now_reg};
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_limited_next = limited_reg;
                    out_status_next  = status_reg;
                    out_count_next   = evict_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CFG_CAP_W'(10);
            rate_reg      <= CFG_RATE_W'(256);
            timeout_reg   <= CFG_TIMEOUT_W'(60);
            valid_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            rate_reg      <= rate_next;
            timeout_reg   <= timeout_next;
            valid_reg     <= valid_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg    <= scan_idx_next;
        chk_idx_reg     <= chk_idx_next;
        req_type_reg    <= req_type_next;
        key_reg         <= key_next;
        now_reg         <= now_next;
        found_reg       <= found_next;
        slot_reg        <= slot_next;
        free_found_reg  <= free_found_next;
        free_reg        <= free_next;
        tok_reg         <= tok_next;
        elapsed_reg     <= elapsed_next;
        prod_reg        <= prod_next;
        fill_reg        <= fill_next;
        limited_reg     <= limited_next;
        status_reg      <= status_next;
        evict_reg       <= evict_next;
        out_limited_reg <= out_limited_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
    end

endmodule
